>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is low.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> src/mict_pkg.sv
// ----------------------------------------------------------------------------
// mict_pkg
// Shared constants, types and the hash for the multiset intersection table.
// ----------------------------------------------------------------------------
package mict_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W         = 32;
    localparam int CNT_W         = 11;
    localparam int KIND_W        = 2;
    localparam int ENTRY_W       = 1 + CNT_W + KEY_W;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [USED_W-1:0] USED_MAX = USED_W'(TABLE_ENTRIES);
    localparam logic [IDX_W:0]    ENTRIES_EXT = (IDX_W + 1)'(TABLE_ENTRIES);

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PROBE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    // One table slot. occupied with count zero marks an erased slot.
    typedef struct packed {
        logic             occupied;
        logic [CNT_W-1:0] count;
        logic [KEY_W-1:0] key;
    } t_entry;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        t_entry             wdata;
        logic [IDX_W-1:0]   raddr;
    } t_ram_req;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] value_out;
        logic             matched;
        logic             full_res;
    } t_result;

    // XOR-fold of the key down to a slot index, then one fold into range.
    function automatic logic [IDX_W-1:0] f_hash(input logic [KEY_W-1:0] key);
        logic [IDX_W-1:0] h;
        h = '0;
        for (int i = 0; i < KEY_W; i++) begin
            h[i % IDX_W] = h[i % IDX_W] ^ key[i];
        end
        if ({1'b0, h} >= ENTRIES_EXT) begin
            h = h - ENTRIES_EXT[IDX_W-1:0];
        end
        return h;
    endfunction

endpackage

>>> src/mict_if.sv
// ----------------------------------------------------------------------------
// mict_in_if / mict_res_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mict_in_if;
    logic                            valid;
    logic                            ready;
    logic [mict_pkg::KIND_W-1:0]     kind;
    logic signed [mict_pkg::KEY_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface mict_res_if;
    logic                            valid;
    logic                            ready;
    logic signed [mict_pkg::KEY_W-1:0] value_out;
    logic                            matched;
    logic                            full_res;

    modport source (output valid, output value_out, output matched, output full_res,
                    input ready);
    modport sink   (input valid, input value_out, input matched, input full_res,
                    output ready);
endinterface

>>> src/mict_ram.sv
// ----------------------------------------------------------------------------
// mict_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mict_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/mict_ctrl.sv
// ----------------------------------------------------------------------------
// mict_ctrl
// Sequencer: hashes the key, probes linearly one slot per cycle while the
// output is free, updates the slot in place, and runs the clearing pass.
// ----------------------------------------------------------------------------
module mict_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mict_in_if.sink            i_item,
    input  logic               i_out_free,
    input  mict_pkg::t_entry   i_rd_entry,
    output mict_pkg::t_ram_req o_ram_req,
    output mict_pkg::t_result  o_result
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_CHECK = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [mict_pkg::IDX_W-1:0]  r_addr, n_addr;
    logic [mict_pkg::IDX_W-1:0]  r_steps, n_steps;
    logic                        r_tomb_vld, n_tomb_vld;
    logic [mict_pkg::IDX_W-1:0]  r_tomb_addr, n_tomb_addr;
    logic [mict_pkg::USED_W-1:0] r_used, n_used;
    logic                        r_fin, n_fin;
    logic [mict_pkg::KIND_W-1:0] r_kind, n_kind;
    logic [mict_pkg::KEY_W-1:0]  r_key, n_key;

    logic                        slot_hit;
    logic                        slot_empty;
    logic                        slot_tomb;
    logic                        slot_last;
    logic [mict_pkg::IDX_W-1:0]  addr_next;

    assign slot_hit   = i_rd_entry.occupied && (i_rd_entry.count != '0)
                        && (i_rd_entry.key == r_key);
    assign slot_empty = !i_rd_entry.occupied;
    assign slot_tomb  = i_rd_entry.occupied && (i_rd_entry.count == '0);
    assign slot_last  = (r_steps == mict_pkg::LAST_IDX);
    assign addr_next  = (r_addr == mict_pkg::LAST_IDX) ? '0 : r_addr + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_steps     = r_steps;
        n_tomb_vld  = r_tomb_vld;
        n_tomb_addr = r_tomb_addr;
        n_used      = r_used;
        n_fin       = r_fin;
        n_kind      = r_kind;
        n_key       = r_key;

        i_item.ready      = 1'b0;
        o_ram_req.we      = 1'b0;
        o_ram_req.waddr   = r_addr;
        o_ram_req.wdata   = '0;
        o_result          = '0;

        unique case (r_state)
            ST_IDLE: begin
                i_item.ready = 1'b1;
                if (i_item.valid) begin
                    n_kind     = i_item.kind;
                    n_key      = unsigned'(i_item.value);
                    n_steps    = '0;
                    n_tomb_vld = 1'b0;
                    if (i_item.kind == mict_pkg::KIND_FINISH) begin
                        n_state = ST_CLEAR;
                        n_addr  = '0;
                        n_fin   = 1'b1;
                    end else begin
                        n_state = ST_CHECK;
                        n_addr  = mict_pkg::f_hash(unsigned'(i_item.value));
                    end
                end
            end

            ST_CHECK: begin
                if (i_out_free) begin
                    case (r_kind)
                        mict_pkg::KIND_LOAD: begin
                            if (slot_hit) begin
                                o_ram_req.we             = 1'b1;
                                o_ram_req.wdata          = i_rd_entry;
                                if (i_rd_entry.count != mict_pkg::CNT_MAX) begin
                                    o_ram_req.wdata.count = i_rd_entry.count + 1'b1;
                                end
                                o_result.valid = 1'b1;
                                n_state        = ST_IDLE;
                            end else if (slot_empty || slot_last) begin
                                o_result.valid = 1'b1;
                                n_state        = ST_IDLE;
                                if (r_used == mict_pkg::USED_MAX) begin
                                    o_result.full_res = 1'b1;
                                end else begin
                                    // reuse the first erased slot on the path
                                    o_ram_req.we             = 1'b1;
                                    o_ram_req.waddr          = r_tomb_vld ? r_tomb_addr
                                                                          : r_addr;
                                    o_ram_req.wdata.occupied = 1'b1;
                                    o_ram_req.wdata.count    = mict_pkg::CNT_W'(1);
                                    o_ram_req.wdata.key      = r_key;
                                    n_used                   = r_used + 1'b1;
                                end
                            end else begin
                                if (slot_tomb && !r_tomb_vld) begin
                                    n_tomb_vld  = 1'b1;
                                    n_tomb_addr = r_addr;
                                end
                                n_addr  = addr_next;
                                n_steps = r_steps + 1'b1;
                            end
                        end

                        mict_pkg::KIND_PROBE: begin
                            if (slot_hit) begin
                                o_ram_req.we          = 1'b1;
                                o_ram_req.wdata       = i_rd_entry;
                                o_ram_req.wdata.count = i_rd_entry.count - 1'b1;
                                if (i_rd_entry.count == mict_pkg::CNT_W'(1)) begin
                                    n_used = r_used - 1'b1;
                                end
                                o_result.valid     = 1'b1;
                                o_result.value_out = r_key;
                                o_result.matched   = 1'b1;
                                n_state            = ST_IDLE;
                            end else if (slot_empty || slot_last) begin
                                o_result.valid = 1'b1;
                                n_state        = ST_IDLE;
                            end else begin
                                n_addr  = addr_next;
                                n_steps = r_steps + 1'b1;
                            end
                        end

                        default: begin
                            o_result.valid = 1'b1;
                            n_state        = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_CLEAR: begin
                o_ram_req.we = 1'b1;
                if (r_addr == mict_pkg::LAST_IDX) begin
                    if (!r_fin || i_out_free) begin
                        o_result.valid = r_fin;
                        n_fin          = 1'b0;
                        n_used         = '0;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end

            default: begin
                n_state = ST_CLEAR;
                n_addr  = '0;
            end
        endcase

        // read port follows the next slot so its data is ready when that slot is current
        o_ram_req.raddr = n_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
            r_used  <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_used  <= n_used;
            r_fin   <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_steps     <= n_steps;
        r_tomb_vld  <= n_tomb_vld;
        r_tomb_addr <= n_tomb_addr;
        r_kind      <= n_kind;
        r_key       <= n_key;
    end

endmodule

>>> src/multiset_intersect_count_table.sv
// ----------------------------------------------------------------------------
// multiset_intersect_count_table
// Multiset intersection by a hashed count table held in one RAM.
// ----------------------------------------------------------------------------
//  channel   dir  fields                          handshake
//  i_item    in   kind[1:0], value[31:0]          valid/ready
//  o_res     out  value_out[31:0], matched, full_res  valid/ready
//
//  Load/probe: after the accept, linear probing from the hashed slot
//  examines one slot per cycle while the output is free: only the hashed
//  slot with no collision, up to the whole RAM at worst.
//  Finish: a clearing pass over all TABLE_ENTRIES words, one RAM word a cycle.
//  After reset the same clearing pass runs before the first item is taken.
//  A stalled result holds the sequencer on its current slot; a new item is
//  taken while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module multiset_intersect_count_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mict_in_if.sink    i_item,
    mict_res_if.source o_res
);

    mict_pkg::t_ram_req               ram_req;
    mict_pkg::t_result                result;
    logic [mict_pkg::ENTRY_W-1:0]     rd_data;
    logic                             out_free;

    logic                             r_out_vld;
    logic signed [mict_pkg::KEY_W-1:0] r_value_out;
    logic                             r_matched;
    logic                             r_full_res;

    assign out_free = !r_out_vld || o_res.ready;

    mict_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_out_free (out_free),
        .i_rd_entry (mict_pkg::t_entry'(rd_data)),
        .o_ram_req  (ram_req),
        .o_result   (result)
    );

    mict_ram #(
        .WIDTH (mict_pkg::ENTRY_W),
        .DEPTH (mict_pkg::TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (result.valid) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_value_out <= signed'(result.value_out);
            r_matched   <= result.matched;
            r_full_res  <= result.full_res;
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.value_out = r_value_out;
    assign o_res.matched   = r_matched;
    assign o_res.full_res  = r_full_res;

endmodule

>>> src/mict_checker.sv
// ----------------------------------------------------------------------------
// mict_checker
// Port-level checks for the count table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mict_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [mict_pkg::KEY_W-1:0]    i_value_out,
    input logic                          i_matched,
    input logic                          i_full_res
);

    // the clearing pass blocks input right after reset
    `CHK_NEXT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n, !i_in_ready)

    // one item at a time: no accept in the cycle after an accept
    `CHK_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
              i_out_valid && $stable(i_value_out))

    `CHK_IMPLY(a_flags_excl, i_clk, i_rst_n, i_out_valid, !(i_matched && i_full_res))

    `CHK_IMPLY(a_miss_zero, i_clk, i_rst_n, i_out_valid && !i_matched, i_value_out == '0)

endmodule

bind multiset_intersect_count_table mict_checker u_mict_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_value_out (o_res.value_out),
    .i_matched   (o_res.matched),
    .i_full_res  (o_res.full_res)
);

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the multiset intersection count table item by item: a key-count
// map mirrors the table and predicts each result (match, echo, full flag).
// Directed cases cover extreme keys, count saturation and a full table;
// random jobs of loads, probes and finishes follow, with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    typedef logic [mict_pkg::KEY_W-1:0]  t_key;
    typedef logic [mict_pkg::KIND_W-1:0] t_kind;
    typedef logic [mict_pkg::CNT_W-1:0]  t_cnt;

    localparam t_kind KIND_UNUSED = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned MAX_PRINTED  = 100;
    // ~7k items, each at worst a whole-RAM walk plus both stalls, with margin.
    localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;

    typedef struct packed {
        t_key value_out;
        logic matched;
        logic full_res;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mict_in_if  item_if ();
    mict_res_if res_if ();

    multiset_intersect_count_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if)
    );

    // Mirror of the table contents: key -> remaining count.
    t_cnt        key_count [t_key];
    t_outcome    outcome_q [$];
    t_outcome    oldest;
    int unsigned error_count = 0;
    int unsigned sent_count  = 0;
    int unsigned ready_hold  = 0;
    bit          quiet       = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        longint unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic t_outcome apply_item(input t_kind kind, input t_key key);
        t_outcome r;
        r = '0;
        case (kind)
            mict_pkg::KIND_LOAD: begin
                if (key_count.exists(key)) begin
                    if (key_count[key] < mict_pkg::CNT_MAX)
                        key_count[key] = key_count[key] + 1'b1;
                end else if (key_count.num() >= mict_pkg::TABLE_ENTRIES) begin
                    r.full_res = 1'b1;
                end else begin
                    key_count[key] = t_cnt'(1);
                end
            end
            mict_pkg::KIND_PROBE: begin
                if (key_count.exists(key)) begin
                    r.value_out = key;
                    r.matched   = 1'b1;
                    key_count[key] = key_count[key] - 1'b1;
                    if (key_count[key] == '0) key_count.delete(key);
                end
            end
            mict_pkg::KIND_FINISH: key_count.delete();
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_key got, input t_key want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("tb_top: mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // Result side: ready drops for a drawn number of cycles after each result.
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            res_if.ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            ready_hold = quiet ? 0 : $urandom_range(0, 7);
            if (outcome_q.size() == 0) begin
                report_mismatch("result with nothing pending", res_if.value_out, '0);
            end else begin
                oldest = outcome_q.pop_front();
                if (res_if.value_out !== oldest.value_out)
                    report_mismatch("value_out", res_if.value_out, oldest.value_out);
                if (res_if.matched !== oldest.matched)
                    report_mismatch("matched", t_key'(res_if.matched), t_key'(oldest.matched));
                if (res_if.full_res !== oldest.full_res)
                    report_mismatch("full_res", t_key'(res_if.full_res),
                                    t_key'(oldest.full_res));
            end
        end
    end

    task automatic send_item(input t_kind kind, input t_key value);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.kind  <= kind;
        item_if.value <= value;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        outcome_q = {outcome_q, apply_item(kind, value)};
        if (kind != KIND_UNUSED) sent_count++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
    endtask

    // valid drops first so the last item is not taken a second time
    task automatic wait_for_outcomes();
        release_input();
        while (outcome_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_key pick_key(input t_key base);
        int unsigned b;
        b = $urandom_range(0, mict_pkg::KEY_W - mict_pkg::IDX_W - 1);
        case ($urandom_range(0, 5))
            0: return {1'b1, 31'b0};
            1: return {1'b0, {31{1'b1}}};
            2: return $urandom_range(0, 3) == 0 ? '1 : '0;
            3: return t_key'($urandom_range(0, 15));
            // flips two bits that fold onto the same hash bit: same slot
            4: return base ^ ((t_key'(1) << b) | (t_key'(1) << (b + mict_pkg::IDX_W)));
            default: return $urandom();
        endcase
    endfunction

    task automatic test_basic_cases();
        send_item(mict_pkg::KIND_LOAD, 32'h8000_0000);
        send_item(mict_pkg::KIND_LOAD, 32'h7FFF_FFFF);
        send_item(mict_pkg::KIND_LOAD, 32'h0000_0000);
        send_item(mict_pkg::KIND_LOAD, 32'hFFFF_FFFF);
        send_item(mict_pkg::KIND_LOAD, 32'hFFFF_FFFF);
        send_item(mict_pkg::KIND_LOAD, 32'h0000_0001);
        send_item(KIND_UNUSED, 32'h1234_5678);
        send_item(mict_pkg::KIND_PROBE, 32'h7FFF_FFFF);
        send_item(mict_pkg::KIND_PROBE, 32'h7FFF_FFFF);
        // key zero matched: echo is zero but matched is set
        send_item(mict_pkg::KIND_PROBE, 32'h0000_0000);
        send_item(mict_pkg::KIND_PROBE, 32'hFFFF_FFFF);
        send_item(mict_pkg::KIND_PROBE, 32'hFFFF_FFFF);
        send_item(mict_pkg::KIND_PROBE, 32'hFFFF_FFFF);
        send_item(mict_pkg::KIND_PROBE, 32'h5555_5555);
        send_item(KIND_UNUSED, 32'hFFFF_FFFF);
        send_item(mict_pkg::KIND_LOAD, 32'h7FFF_FFFF);
        send_item(mict_pkg::KIND_PROBE, 32'h7FFF_FFFF);
        send_item(mict_pkg::KIND_FINISH, 32'hAAAA_AAAA);
        send_item(mict_pkg::KIND_PROBE, 32'h8000_0000);
        send_item(mict_pkg::KIND_PROBE, 32'h0000_0001);
        send_item(mict_pkg::KIND_LOAD, 32'h0000_0001);
        send_item(mict_pkg::KIND_PROBE, 32'h0000_0001);
        // sender holds off until the table has answered everything
        wait_for_outcomes();
    endtask

    task automatic test_count_saturation();
        t_key key;
        key = $urandom();
        repeat (int'(mict_pkg::CNT_MAX) + 3) send_item(mict_pkg::KIND_LOAD, key);
        repeat (int'(mict_pkg::CNT_MAX) + 1) send_item(mict_pkg::KIND_PROBE, key);
        send_item(mict_pkg::KIND_FINISH, $urandom());
        wait_for_outcomes();
    endtask

    task automatic test_table_full();
        t_key held [$];
        t_key key;
        quiet = 1'b1;
        while (key_count.num() < mict_pkg::TABLE_ENTRIES) begin
            key = $urandom();
            if (!key_count.exists(key)) begin
                send_item(mict_pkg::KIND_LOAD, key);
                held = {held, key};
            end
        end
        quiet = 1'b0;
        repeat (2) begin
            do key = $urandom(); while (key_count.exists(key));
            send_item(mict_pkg::KIND_LOAD, key);
        end
        send_item(mict_pkg::KIND_LOAD, held[$urandom_range(0, held.size() - 1)]);
        do key = $urandom(); while (key_count.exists(key));
        send_item(mict_pkg::KIND_PROBE, key);
        // free one slot, refill it, then full again
        send_item(mict_pkg::KIND_PROBE, held[0]);
        send_item(mict_pkg::KIND_PROBE, held[0]);
        send_item(mict_pkg::KIND_LOAD, key);
        do key = $urandom(); while (key_count.exists(key));
        send_item(mict_pkg::KIND_LOAD, key);
        send_item(mict_pkg::KIND_FINISH, $urandom());
        wait_for_outcomes();
    endtask

    task automatic test_random_jobs();
        t_key        pool [$];
        int unsigned stop_at, n_keys, n_loads, n_probes, li, pi;
        bit          mixed;
        stop_at = sent_count + RANDOM_ITEMS;
        while (sent_count < stop_at) begin
            quiet = ($urandom_range(0, 3) == 0);
            pool.delete();
            pool = {pool, t_key'($urandom())};
            n_keys = $urandom_range(0, 11);
            repeat (n_keys) pool = {pool, pick_key(pool[0])};
            n_loads  = $urandom_range(0, 24);
            n_probes = $urandom_range(0, 24);
            mixed    = ($urandom_range(0, 3) == 0);
            li = 0;
            pi = 0;
            while (li < n_loads || pi < n_probes) begin
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 2))
                        0: send_item(KIND_UNUSED, $urandom());
                        1: send_item(mict_pkg::KIND_PROBE, $urandom());
                        default: send_item(mict_pkg::KIND_LOAD, $urandom());
                    endcase
                end else if (pi >= n_probes ||
                             (li < n_loads && (!mixed || $urandom_range(0, 1) == 0))) begin
                    send_item(mict_pkg::KIND_LOAD, pool[$urandom_range(0, pool.size() - 1)]);
                    li++;
                end else begin
                    send_item(mict_pkg::KIND_PROBE, pool[$urandom_range(0, pool.size() - 1)]);
                    pi++;
                end
            end
            if ($urandom_range(0, 4) != 0) send_item(mict_pkg::KIND_FINISH, $urandom());
            if ($urandom_range(0, 5) == 0) wait_for_outcomes();
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        item_if.valid = 1'b0;
        item_if.kind  = mict_pkg::KIND_LOAD;
        item_if.value = '0;
        res_if.ready  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_cases();
        test_count_saturation();
        test_table_full();
        test_random_jobs();

        release_input();
        wait_for_outcomes();
        // room for a clearing pass and any stray result
        repeat (mict_pkg::TABLE_ENTRIES + 32) @(posedge i_clk);
        if (error_count == 0 && outcome_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/mict_pkg.sv
src/mict_if.sv
src/mict_ram.sv
src/mict_ctrl.sv
src/multiset_intersect_count_table.sv
src/mict_checker.sv
sim/tb_top.sv
